// ===== rtl/dlcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlcs_pkg: shared types and constants for dark-line centroid steering
// Payload structs, register indexes, reset values and controller links.
// ----------------------------------------------------------------------------
package dlcs_pkg;

   // field widths
   localparam int PIXEL_W    = 8;
   localparam int LEVEL_SHR  = 3;
   localparam int THRESH_W   = 5;
   localparam int EDGE_W     = 7;
   localparam int CENTER_W   = 7;
   localparam int TOTAL_W    = 7;
   localparam int DUTY_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_EDGE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_EDGE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_LINE_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_FULL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_OFF       = 3'd5;

   // register reset values
   localparam logic [THRESH_W-1:0] RST_DARK_THRESHOLD = 5'd10;
   localparam logic [EDGE_W-1:0]   RST_LEFT_EDGE      = 7'd30;
   localparam logic [EDGE_W-1:0]   RST_RIGHT_EDGE     = 7'd50;
   localparam logic [EDGE_W-1:0]   RST_NO_LINE_CENTER = 7'd40;
   localparam logic [DUTY_W-1:0]   RST_DUTY_FULL      = 16'd2400;
   localparam logic [DUTY_W-1:0]   RST_DUTY_OFF       = 16'd1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center;
      logic                line_found;
      logic [TOTAL_W-1:0]  dark_total;
      logic [DUTY_W-1:0]   wheel_a_duty;
      logic [DUTY_W-1:0]   wheel_b_duty;
   } rsp_type;

   typedef struct packed {
      logic [THRESH_W-1:0] dark_threshold;
      logic [EDGE_W-1:0]   left_edge;
      logic [EDGE_W-1:0]   right_edge;
      logic [EDGE_W-1:0]   no_line_center;
      logic [DUTY_W-1:0]   duty_full;
      logic [DUTY_W-1:0]   duty_off;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accum;     // sample transfer, update the row accumulators
      logic start;     // row end transfer, load divider and clear the row
      logic step;      // one divider iteration
      logic load;      // capture the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/dark_line_centroid_steering.sv =====
// ----------------------------------------------------------------------------
// dark_line_centroid_steering: line-follower centroid and wheel duty select
// Top level joining the registers, controller and datapath.
// ----------------------------------------------------------------------------
// One camera sample is taken per cycle while the block is not busy. The
// transfer that carries row_end is followed by a busy period: the mean
// position comes from a restoring divider producing one quotient bit per
// cycle over a row sum of SUM_W = clog2(ROW_SAMPLES*(ROW_SAMPLES-1)/2 + 1)
// bits, and then the result register is loaded. The result register lets
// a new row start while the previous result waits; when the next row's
// divide finishes before that result is taken, the load waits and the
// input stays stalled until the slot frees. Samples past ROW_SAMPLES in a
// row are ignored, but their row_end still closes it. The user must write
// configuration only while the block is idle; the block does not enforce it.
module dark_line_centroid_steering #(
   parameter int ROW_SAMPLES = 80
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dlcs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dlcs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [dlcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dlcs_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // configuration registers
   dlcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencing
   dlcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_data.row_end),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // accumulate, divide, steer
   dlcs_dp #(
      .ROW_SAMPLES (ROW_SAMPLES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/dlcs_csr.sv =====
// ----------------------------------------------------------------------------
// dlcs_csr: configuration registers
// Six write-only registers, cut to their widths; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module dlcs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dlcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output dlcs_pkg::cfg_type                    cfg
);
   import dlcs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DARK_THRESHOLD: cfg_in.dark_threshold = csr_wdata[THRESH_W-1:0];
            CSR_LEFT_EDGE:      cfg_in.left_edge      = csr_wdata[EDGE_W-1:0];
            CSR_RIGHT_EDGE:     cfg_in.right_edge     = csr_wdata[EDGE_W-1:0];
            CSR_NO_LINE_CENTER: cfg_in.no_line_center = csr_wdata[EDGE_W-1:0];
            CSR_DUTY_FULL:      cfg_in.duty_full      = csr_wdata[DUTY_W-1:0];
            CSR_DUTY_OFF:       cfg_in.duty_off       = csr_wdata[DUTY_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold <= RST_DARK_THRESHOLD;
         cfg_ff.left_edge      <= RST_LEFT_EDGE;
         cfg_ff.right_edge     <= RST_RIGHT_EDGE;
         cfg_ff.no_line_center <= RST_NO_LINE_CENTER;
         cfg_ff.duty_full      <= RST_DUTY_FULL;
         cfg_ff.duty_off       <= RST_DUTY_OFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dlcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlcs_ctrl: sequencing controller
// Takes samples, runs the end-of-row divider and owns the result valid.
// ----------------------------------------------------------------------------
module dlcs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_row_end,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  dlcs_pkg::sts_type  sts,
   output dlcs_pkg::cmd_type  cmd
);
   import dlcs_pkg::*;

   localparam logic ST_ACCUM = 1'b0;
   localparam logic ST_DIV   = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_row_end) begin
                  cmd.start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!sts.div_done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/dlcs_dp.sv =====
// ----------------------------------------------------------------------------
// dlcs_dp: accumulation, bit-serial divider and steering datapath
// Row accumulators, restoring divider one quotient bit per step, result reg.
// ----------------------------------------------------------------------------
module dlcs_dp #(
   parameter int ROW_SAMPLES = 80
) (
   input  logic               clock,
   input  logic               reset,
   input  dlcs_pkg::req_type  req_data,
   input  dlcs_pkg::cfg_type  cfg,
   input  dlcs_pkg::cmd_type  cmd,
   output dlcs_pkg::sts_type  sts,
   output dlcs_pkg::rsp_type  rsp_data
);
   import dlcs_pkg::*;

   localparam int POS_W  = $clog2(ROW_SAMPLES + 1);
   localparam int CNT_W  = POS_W;
   localparam int SUM_W  = $clog2(ROW_SAMPLES * (ROW_SAMPLES - 1) / 2 + 1);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int CMP_W  = (POS_W > EDGE_W) ? POS_W : EDGE_W;

   logic [POS_W-1:0]  pos_ff,  pos_in,  pos_upd;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in,  cnt_upd;
   logic [SUM_W-1:0]  sum_ff,  sum_in,  sum_upd;
   logic [SUM_W-1:0]  quo_ff,  quo_in;
   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W-1:0]  dvs_ff,  dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   rsp_type           rsp_ff,  rsp_in;

   logic [THRESH_W-1:0] level;
   logic                dark;
   logic [CNT_W:0]      rem_shift;
   logic [CNT_W:0]      rem_diff;
   logic                fits;
   logic                found;
   logic [CMP_W-1:0]    center_cmp;

   // one sample: cut to five bits and test against the threshold
   assign level = THRESH_W'(req_data.pixel >> LEVEL_SHR);
   assign dark  = level < cfg.dark_threshold;

   // accumulator update, position saturates at the row length
   always_comb begin
      pos_upd = pos_ff;
      cnt_upd = cnt_ff;
      sum_upd = sum_ff;
      if (pos_ff < POS_W'(ROW_SAMPLES)) begin
         if (dark) begin
            cnt_upd = cnt_ff + CNT_W'(1);
            sum_upd = sum_ff + SUM_W'(pos_ff);
         end
         pos_upd = pos_ff + POS_W'(1);
      end
   end

   // row accumulators, cleared at each row end
   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (cmd.start) begin
         pos_in = '0;
         cnt_in = '0;
         sum_in = '0;
      end else if (cmd.accum) begin
         pos_in = pos_upd;
         cnt_in = cnt_upd;
         sum_in = sum_upd;
      end
   end

   // restoring divider iteration
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      if (cmd.start) begin
         quo_in  = sum_upd;
         rem_in  = '0;
         dvs_in  = cnt_upd;
         step_in = STEP_W'(SUM_W);
      end else if (cmd.step) begin
         quo_in  = (quo_ff << 1) | SUM_W'(fits);
         rem_in  = fits ? CNT_W'(rem_diff) : CNT_W'(rem_shift);
         step_in = step_ff - STEP_W'(1);
      end
   end

   assign sts.div_done = (step_ff == '0);

   // centre select and steering decision
   assign found      = (dvs_ff != '0);
   assign center_cmp = found ? CMP_W'(quo_ff) : CMP_W'(cfg.no_line_center);

   always_comb begin
      rsp_in            = rsp_ff;
      if (cmd.load) begin
         rsp_in.center     = CENTER_W'(center_cmp);
         rsp_in.line_found = found;
         rsp_in.dark_total = TOTAL_W'(dvs_ff);
         priority if (center_cmp < CMP_W'(cfg.left_edge)) begin
            rsp_in.wheel_a_duty = cfg.duty_off;
            rsp_in.wheel_b_duty = cfg.duty_full;
         end else if (center_cmp > CMP_W'(cfg.right_edge)) begin
            rsp_in.wheel_a_duty = cfg.duty_full;
            rsp_in.wheel_b_duty = cfg.duty_off;
         end else begin
            rsp_in.wheel_a_duty = cfg.duty_full;
            rsp_in.wheel_b_duty = cfg.duty_full;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         step_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         step_ff <= step_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/dlcs_checker.sv =====
// ----------------------------------------------------------------------------
// dlcs_props: port-level checks for dark-line centroid steering
// Watches the top level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module dlcs_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input dlcs_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input dlcs_pkg::rsp_type                 rsp_data
);
   import dlcs_pkg::*;

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // a row end transfer starts the divider, so the input stalls next cycle
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.row_end |=> !req_ready)
      else $error("input ready right after a row end transfer");

   // no line found means no dark samples counted
   a_found_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.line_found |-> rsp_data.dark_total == '0)
      else $error("dark samples reported without a line");

endmodule

bind dark_line_centroid_steering dlcs_props u_dlcs_props (.*);

// ===== dv/dlcs_checker.sv =====
// ----------------------------------------------------------------------------
// dlcs_checker: result predictor and scoreboard for dark-line centroid steering
// Watches the sample, result and register ports, keeps its own copy of the
// row accumulators and settings, and compares every result transfer with the
// oldest predicted steering result.
// ----------------------------------------------------------------------------
module dlcs_checker #(
   parameter int ROW_SAMPLES = 80
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  dlcs_pkg::req_type                 req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  dlcs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [dlcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                rows_pending,
   output int                                rows_checked
);
   import dlcs_pkg::*;

   // shadow settings and row accumulators
   cfg_type             shadow_cfg;
   logic [TOTAL_W-1:0]  row_pos;
   logic [TOTAL_W-1:0]  dark_cnt;
   logic [11:0]         pos_sum;

   rsp_type             steer_queue[$];
   int                  fails;
   int                  checked;

   // fold one sample into the row, predict the steering result on row end
   task automatic take_sample(input req_type s);
      logic [THRESH_W-1:0] level;
      rsp_type             steer;
      int                  mid;
      level = THRESH_W'(s.pixel >> LEVEL_SHR);
      if (row_pos < ROW_SAMPLES) begin
         if (level < shadow_cfg.dark_threshold) begin
            dark_cnt = dark_cnt + 1'b1;
            pos_sum  = pos_sum + row_pos;
         end
         row_pos = row_pos + 1'b1;
      end
      if (s.row_end) begin
         steer.line_found = (dark_cnt != 0);
         if (steer.line_found)
            mid = int'(pos_sum) / int'(dark_cnt);
         else
            mid = int'(shadow_cfg.no_line_center);
         // left test comes first, so it wins when the edges are crossed
         if (mid < int'(shadow_cfg.left_edge)) begin
            steer.wheel_a_duty = shadow_cfg.duty_off;
            steer.wheel_b_duty = shadow_cfg.duty_full;
         end else if (mid > int'(shadow_cfg.right_edge)) begin
            steer.wheel_a_duty = shadow_cfg.duty_full;
            steer.wheel_b_duty = shadow_cfg.duty_off;
         end else begin
            steer.wheel_a_duty = shadow_cfg.duty_full;
            steer.wheel_b_duty = shadow_cfg.duty_full;
         end
         steer.center     = CENTER_W'(mid);
         steer.dark_total = dark_cnt;
         steer_queue.push_back(steer);
         row_pos  = '0;
         dark_cnt = '0;
         pos_sum  = '0;
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   // track every transfer on the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_cfg.dark_threshold = RST_DARK_THRESHOLD;
         shadow_cfg.left_edge      = RST_LEFT_EDGE;
         shadow_cfg.right_edge     = RST_RIGHT_EDGE;
         shadow_cfg.no_line_center = RST_NO_LINE_CENTER;
         shadow_cfg.duty_full      = RST_DUTY_FULL;
         shadow_cfg.duty_off       = RST_DUTY_OFF;
         row_pos  = '0;
         dark_cnt = '0;
         pos_sum  = '0;
         steer_queue.delete();
      end else begin
         // register writes, cut to each register's width
         if (csr_we) begin
            case (csr_index)
               CSR_DARK_THRESHOLD: shadow_cfg.dark_threshold = csr_wdata[THRESH_W-1:0];
               CSR_LEFT_EDGE:      shadow_cfg.left_edge      = csr_wdata[EDGE_W-1:0];
               CSR_RIGHT_EDGE:     shadow_cfg.right_edge     = csr_wdata[EDGE_W-1:0];
               CSR_NO_LINE_CENTER: shadow_cfg.no_line_center = csr_wdata[EDGE_W-1:0];
               CSR_DUTY_FULL:      shadow_cfg.duty_full      = csr_wdata[DUTY_W-1:0];
               CSR_DUTY_OFF:       shadow_cfg.duty_off       = csr_wdata[DUTY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_sample(req_data);
         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (steer_queue.size() == 0) begin
               $error("result transfer with no row pending: center %0d", rsp_data.center);
               fails++;
            end else begin
               want = steer_queue.pop_front();
               check_field("center", want.center, rsp_data.center);
               check_field("line_found", want.line_found, rsp_data.line_found);
               check_field("dark_total", want.dark_total, rsp_data.dark_total);
               check_field("wheel_a_duty", want.wheel_a_duty, rsp_data.wheel_a_duty);
               check_field("wheel_b_duty", want.wheel_b_duty, rsp_data.wheel_b_duty);
               checked++;
            end
         end
      end
      rows_pending <= steer_queue.size();
      fail_count   <= fails;
      rows_checked <= checked;
   end

endmodule

// ===== dv/dark_line_centroid_steering_tb.sv =====
// ----------------------------------------------------------------------------
// dark_line_centroid_steering_tb: top level of the steering block testbench
// Drives camera rows and register settings with random idling on both
// channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module dark_line_centroid_steering_tb;
   import dlcs_pkg::*;

   localparam int ROW_SAMPLES    = 80;
   localparam int SAMPLE_TARGET  = 1200;
   localparam int ROW_TARGET     = 20;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 1000;

   // indexes past the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int      fail_count;
   int      rows_pending;
   int      rows_checked;

   cfg_type cfg_now;
   int      req_idle_max;
   int      rsp_idle_max;
   int      row_fill;
   int      samples_sent;
   int      rows_sent;
   int      long_rows;
   int      settings_done;
   int      quiet;

   dark_line_centroid_steering #(
      .ROW_SAMPLES (ROW_SAMPLES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dlcs_checker #(
      .ROW_SAMPLES (ROW_SAMPLES)
   ) steer_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .rows_pending (rows_pending),
      .rows_checked (rows_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   initial begin
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stall before each transfer
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (rsp_idle_max == 0) ? 0 : $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // one sample transfer; valid stays high when the next one follows at once
   task automatic drive_sample(input logic [PIXEL_W-1:0] pix, input logic last);
      int gap;
      gap = (req_idle_max == 0) ? 0 : $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {pix, last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // samples past the row length are dropped by the block
      if (row_fill < ROW_SAMPLES) begin
         samples_sent++;
         row_fill++;
      end
      if (last) begin
         rows_sent++;
         row_fill = 0;
      end
   endtask

   // stop sending and let every pending row come out
   task automatic wait_rows_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write all registers, optional junk above widths (right edge: always)
   task automatic apply_setting(input cfg_type c, input bit junk);
      logic [CSR_DATA_W-1:0] hi;
      hi = junk ? CSR_DATA_W'($urandom) : '0;
      put_reg(CSR_DARK_THRESHOLD, {hi[CSR_DATA_W-1:THRESH_W], c.dark_threshold});
      put_reg(CSR_LEFT_EDGE, {hi[CSR_DATA_W-1:EDGE_W], c.left_edge});
      put_reg(CSR_RIGHT_EDGE, {~hi[CSR_DATA_W-1:EDGE_W], c.right_edge});
      put_reg(CSR_NO_LINE_CENTER, {hi[CSR_DATA_W-2:EDGE_W-1], c.no_line_center});
      put_reg(CSR_DUTY_FULL, c.duty_full);
      put_reg(CSR_DUTY_OFF, c.duty_off);
      if (junk) begin
         put_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom));
         put_reg(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      end
      csr_we <= 1'b0;
      cfg_now = c;
      settings_done++;
   endtask

   // a field value at either end of its range or anywhere between
   function automatic int pick_value(input int hi_val);
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 0)
         return 0;
      else if (sel == 1)
         return hi_val;
      else
         return $urandom_range(0, hi_val);
   endfunction

   function automatic cfg_type random_setting();
      cfg_type c;
      c.dark_threshold = THRESH_W'(pick_value(31));
      c.left_edge      = EDGE_W'(pick_value(79));
      c.right_edge     = EDGE_W'(pick_value(79));
      c.no_line_center = EDGE_W'(pick_value(79));
      c.duty_full      = DUTY_W'(pick_value(65535));
      c.duty_off       = DUTY_W'(pick_value(65535));
      return c;
   endfunction

   // a byte that reads as dark or light under the present threshold
   function automatic logic [PIXEL_W-1:0] pick_pixel(input bit dark);
      int cut;
      cut = int'(cfg_now.dark_threshold) * 8;
      if (dark)
         return (cut == 0) ? 8'd0 : PIXEL_W'($urandom_range(0, cut - 1));
      else
         return PIXEL_W'($urandom_range(cut, 255));
   endfunction

   // kinds: random bytes, dark band with noise, all light, all dark
   task automatic send_row(input int len, input int kind);
      int  band_lo;
      int  band_w;
      bit  dark;
      logic [PIXEL_W-1:0] pix;
      band_lo = $urandom_range(0, ROW_SAMPLES - 1);
      band_w  = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
         dark = (i >= band_lo) && (i < band_lo + band_w);
         if ($urandom_range(0, 15) == 0)
            dark = !dark;
         case (kind)
            0:       pix = PIXEL_W'($urandom);
            2:       pix = pick_pixel(1'b0);
            3:       pix = pick_pixel(1'b1);
            default: pix = pick_pixel(dark);
         endcase
         drive_sample(pix, i == len - 1);
      end
      if (len > ROW_SAMPLES)
         long_rows++;
   endtask

   // stimulus
   initial begin
      cfg_type c;
      int      len;
      int      sel;
      int      kind;
      int      rows_since_cfg;
      bit      first_row;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_idle_max = 13;
      rsp_idle_max = 13;
      row_fill     = 0;
      samples_sent = 0;
      rows_sent    = 0;
      long_rows    = 0;
      settings_done = 0;
      cfg_now.dark_threshold = RST_DARK_THRESHOLD;
      cfg_now.left_edge      = RST_LEFT_EDGE;
      cfg_now.right_edge     = RST_RIGHT_EDGE;
      cfg_now.no_line_center = RST_NO_LINE_CENTER;
      cfg_now.duty_full      = RST_DUTY_FULL;
      cfg_now.duty_off       = RST_DUTY_OFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single dark sample, no line, threshold boundary
      drive_sample(8'd0, 1'b1);
      drive_sample(8'd255, 1'b1);
      drive_sample(8'd80, 1'b0);
      drive_sample(8'd79, 1'b0);
      drive_sample(8'd255, 1'b0);
      drive_sample(8'd0, 1'b1);
      wait_rows_done();

      // top threshold with crossed edges and full-scale duties
      c.dark_threshold = 5'd31;
      c.left_edge      = 7'd60;
      c.right_edge     = 7'd20;
      c.no_line_center = 7'd40;
      c.duty_full      = 16'hFFFF;
      c.duty_off       = 16'h0000;
      apply_setting(c, 1'b1);
      drive_sample(8'd255, 1'b1);
      drive_sample(8'd247, 1'b1);
      drive_sample(8'd247, 1'b0);
      drive_sample(8'd255, 1'b0);
      drive_sample(8'd0, 1'b1);
      wait_rows_done();

      // zero threshold: nothing is dark, centre at the far end
      c.dark_threshold = 5'd0;
      c.left_edge      = 7'd0;
      c.right_edge     = 7'd79;
      c.no_line_center = 7'd79;
      c.duty_full      = 16'h0000;
      c.duty_off       = 16'hFFFF;
      apply_setting(c, 1'b0);
      drive_sample(8'd0, 1'b1);
      drive_sample(8'd7, 1'b1);
      wait_rows_done();

      // centre beyond the right edge
      c.right_edge = 7'd0;
      c.duty_full  = 16'd1234;
      c.duty_off   = 16'd77;
      apply_setting(c, 1'b1);
      drive_sample(8'd128, 1'b1);
      wait_rows_done();

      // back to a working threshold for the random rows
      c.dark_threshold = RST_DARK_THRESHOLD;
      c.left_edge      = RST_LEFT_EDGE;
      c.right_edge     = RST_RIGHT_EDGE;
      c.no_line_center = RST_NO_LINE_CENTER;
      c.duty_full      = RST_DUTY_FULL;
      c.duty_off       = RST_DUTY_OFF;
      apply_setting(c, 1'b0);

      // random rows, settings changed between phases
      rows_since_cfg = 0;
      first_row      = 1'b1;
      while (samples_sent < SAMPLE_TARGET || rows_sent < ROW_TARGET) begin
         if (rows_since_cfg >= 6 && $urandom_range(0, 2) == 0) begin
            wait_rows_done();
            apply_setting(random_setting(), 1'($urandom_range(0, 1)));
            rows_since_cfg = 0;
         end else if ($urandom_range(0, 29) == 0) begin
            wait_rows_done();
         end
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
         sel = $urandom_range(0, 19);
         if (first_row)
            len = ROW_SAMPLES + 8;
         else if (sel < 8)
            len = $urandom_range(1, 20);
         else if (sel < 15)
            len = ROW_SAMPLES;
         else if (sel < 18)
            len = $urandom_range(1, ROW_SAMPLES - 1);
         else
            len = $urandom_range(ROW_SAMPLES + 1, ROW_SAMPLES + 16);
         sel = $urandom_range(0, 19);
         if (sel < 3)
            kind = 0;
         else if (sel < 5)
            kind = 2;
         else if (sel < 8)
            kind = 3;
         else
            kind = 1;
         send_row(len, kind);
         first_row = 1'b0;
         rows_since_cfg++;
      end

      // drain and settle
      wait_rows_done();
      $display("covered %0d samples in %0d rows (%0d over length), %0d register settings",
               samples_sent, rows_sent, long_rows, settings_done);
      $display("compared %0d steering results, idle and stall gaps of 0 to 13 cycles",
               rows_checked);
      if (fail_count == 0 && rows_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
